### rtl/wot_pkg.sv
// Shared types and constants for the walking-one memory test sequencer.
package wot_pkg;

  localparam int unsigned BlockMax  = 4096;
  localparam int unsigned AddrW     = 12;
  localparam int unsigned SizeW     = 13;
  localparam int unsigned MaxRes    = 3;

  localparam logic [SizeW-1:0] SizeCap =
      (BlockMax < 4096) ? SizeW'(BlockMax) : SizeW'(4096);

  // byte address of the block size register on the APB port
  localparam logic [2:0] ADDR_BLOCK_SIZE = 3'd0;

  localparam logic [1:0] FUNC_STEP     = 2'd0;
  localparam logic [1:0] FUNC_RDATA    = 2'd1;
  localparam logic [1:0] FUNC_SET_STEP = 2'd2;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [AddrW-1:0] address;
    logic [7:0]       write_data;
    logic             fail;
    logic             out_of_range;
    logic             last;
  } res_t;

  typedef res_t [MaxRes-1:0] res_set_t;

endpackage

### rtl/walking_one_memory_test.sv
// Walking-one memory test sequencer: top level.
//
// Each input word's results (none to three words) appear from the next
// cycle on, one per cycle while out_ready_i is high. A returned read byte
// gives a single result, so while out_ready_i is high the read sweep runs
// at one input word per cycle. A step command gives up to three results
// (one-hot write, clear of the previous byte, first read request), or one
// verdict if the step lies past the block; the result queue holds three
// entries, and a new input word is taken in the cycle its last queued
// result leaves. Register block_size sits at byte address 0 of the APB
// port, is clamped to 4096 bytes and should only be written while the
// sequencer is idle.
module walking_one_memory_test (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  read_data_i,
  input  logic [15:0] next_step_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [11:0] address_o,
  output logic [7:0]  write_data_o,
  output logic        fail_o,
  output logic        out_of_range_o,
  output logic        last_o
);

  logic [wot_pkg::SizeW-1:0] used_size;
  logic                      accept;
  wot_pkg::res_set_t         res;
  logic [1:0]                res_cnt;
  wot_pkg::res_t             head;

  // accept a word only when the queue can take its whole result set
  assign accept = in_valid_i && in_ready_o;

  wot_apb u_apb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .used_size_o (used_size)
  );

  // advance test state and form results in the accepting cycle
  wot_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (func_i),
    .read_data_i (read_data_i),
    .next_step_i (next_step_i),
    .used_size_i (used_size),
    .res_o       (res),
    .res_cnt_o   (res_cnt)
  );

  // hold results until the consumer takes them
  wot_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res),
    .res_cnt_i   (res_cnt),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .room_o      (in_ready_o),
    .head_o      (head)
  );

  assign kind_o         = head.kind;
  assign address_o      = head.address;
  assign write_data_o   = head.write_data;
  assign fail_o         = head.fail;
  assign out_of_range_o = head.out_of_range;
  assign last_o         = head.last;

endmodule

### rtl/wot_apb.sv
// APB configuration register: block size under test.
module wot_apb (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [wot_pkg::SizeW-1:0] used_size_o
);

  logic [wot_pkg::SizeW-1:0] block_size_q;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == wot_pkg::ADDR_BLOCK_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= wot_pkg::SizeW'(4096);
    end else if (wr_en) begin
      block_size_q <= pwdata[wot_pkg::SizeW-1:0];
    end
  end

  assign prdata = (paddr == wot_pkg::ADDR_BLOCK_SIZE) ?
                  {{(32-wot_pkg::SizeW){1'b0}}, block_size_q} : 32'd0;

  // clamp to the largest block the sequencer can address
  assign used_size_o = (block_size_q > wot_pkg::SizeCap) ? wot_pkg::SizeCap : block_size_q;

endmodule

### rtl/wot_core.sv
// Test state and per-word result generation.
module wot_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [1:0]                func_i,
  input  logic [7:0]                read_data_i,
  input  logic [15:0]               next_step_i,
  input  logic [wot_pkg::SizeW-1:0] used_size_i,
  output wot_pkg::res_set_t         res_o,
  output logic [1:0]                res_cnt_o
);

  logic [15:0]               step_q, step_d;
  logic [11:0]               prev_q, prev_d;
  logic [11:0]               act_byte_q, act_byte_d;
  logic [2:0]                act_bit_q, act_bit_d;
  logic [12:0]               rd_idx_q, rd_idx_d;
  logic                      mis_q, mis_d;
  logic                      busy_q, busy_d;

  logic [12:0]               byte_w;
  logic [12:0]               rd_nxt;
  logic [7:0]                expect_w;
  logic                      mis_w;
  wot_pkg::res_t             r_wr, r_clr, r_rd, r_ver;

  assign byte_w   = step_q[15:3];
  assign rd_nxt   = rd_idx_q + 13'd1;
  assign expect_w = (rd_idx_q == {1'b0, act_byte_q}) ? (8'd1 << act_bit_q) : 8'd0;
  assign mis_w    = mis_q || (read_data_i != expect_w);

  always_comb begin
    step_d     = step_q;
    prev_d     = prev_q;
    act_byte_d = act_byte_q;
    act_bit_d  = act_bit_q;
    rd_idx_d   = rd_idx_q;
    mis_d      = mis_q;
    busy_d     = busy_q;
    res_o      = '0;
    res_cnt_o  = 2'd0;

    r_wr  = '{kind: wot_pkg::KIND_WRITE, address: byte_w[11:0],
              write_data: 8'd1 << step_q[2:0], default: '0};
    r_clr = '{kind: wot_pkg::KIND_WRITE, address: prev_q, default: '0};
    r_rd  = '{kind: wot_pkg::KIND_READ, default: '0};
    r_ver = '{kind: wot_pkg::KIND_VERDICT, default: '0};

    case (func_i)
      wot_pkg::FUNC_STEP: begin
        step_d = step_q + 16'd1;
        if (byte_w >= used_size_i) begin
          busy_d              = 1'b0;
          r_ver.out_of_range  = 1'b1;
          r_ver.last          = 1'b1;
          res_o[0]            = r_ver;
          res_cnt_o           = 2'd1;
        end else begin
          act_byte_d = byte_w[11:0];
          act_bit_d  = step_q[2:0];
          rd_idx_d   = 13'd0;
          mis_d      = 1'b0;
          busy_d     = 1'b1;
          r_rd.last  = 1'b1;
          res_o[0]   = r_wr;
          if (byte_w[11:0] != prev_q) begin
            prev_d    = byte_w[11:0];
            res_o[1]  = r_clr;
            res_o[2]  = r_rd;
            res_cnt_o = 2'd3;
          end else begin
            res_o[1]  = r_rd;
            res_cnt_o = 2'd2;
          end
        end
      end
      wot_pkg::FUNC_RDATA: begin
        if (busy_q) begin
          mis_d     = mis_w;
          rd_idx_d  = rd_nxt;
          res_cnt_o = 2'd1;
          if (rd_nxt < used_size_i) begin
            r_rd.address = rd_nxt[11:0];
            r_rd.last    = 1'b1;
            res_o[0]     = r_rd;
          end else begin
            busy_d     = 1'b0;
            r_ver.fail = mis_w;
            r_ver.last = 1'b1;
            res_o[0]   = r_ver;
          end
        end
      end
      wot_pkg::FUNC_SET_STEP: begin
        step_d = next_step_i - 16'd1;
      end
      default: begin
      end
    endcase

    if (!accept_i) begin
      res_cnt_o = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= '0;
      prev_q     <= '0;
      act_byte_q <= '0;
      act_bit_q  <= '0;
      rd_idx_q   <= '0;
      mis_q      <= 1'b0;
      busy_q     <= 1'b0;
    end else if (accept_i) begin
      step_q     <= step_d;
      prev_q     <= prev_d;
      act_byte_q <= act_byte_d;
      act_bit_q  <= act_bit_d;
      rd_idx_q   <= rd_idx_d;
      mis_q      <= mis_d;
      busy_q     <= busy_d;
    end
  end

endmodule

### rtl/wot_outq.sv
// Result register holding up to three words, drained one per cycle while out_ready_i is high.
module wot_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  wot_pkg::res_set_t res_i,
  input  logic [1:0]        res_cnt_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              room_o,
  output wot_pkg::res_t     head_o
);

  wot_pkg::res_set_t slot_q, slot_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign head_o      = slot_q[0];
  // take a new word once the queue is empty or its final word leaves now
  assign room_o      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      slot_d = res_i;
      cnt_d  = res_cnt_i;
    end else if (pop) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
      cnt_d     = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

### rtl/wot_chk.sv
// Port checker for the walking-one sequencer, bound to the top level.
module wot_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  kind_i,
  input logic [11:0] address_i,
  input logic [7:0]  write_data_i,
  input logic        fail_i,
  input logic        out_of_range_i,
  input logic        last_i
);

  // a stalled result word stays valid and holds its kind, address, write data and last flag
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
      $stable(address_i) && $stable(write_data_i) && $stable(last_i))
    else $error("result word changed while stalled");

  a_verdict_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == wot_pkg::KIND_VERDICT) |->
      last_i && (address_i == 12'd0) && (write_data_i == 8'd0))
    else $error("verdict word malformed");

  a_read_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == wot_pkg::KIND_READ) |->
      last_i && (write_data_i == 8'd0) && !fail_i && !out_of_range_i)
    else $error("read request malformed");

  a_write_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == wot_pkg::KIND_WRITE) |->
      !last_i && !fail_i && !out_of_range_i && $countones(write_data_i) <= 1)
    else $error("write word malformed");

  a_oor_no_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_of_range_i |-> !fail_i)
    else $error("out-of-range verdict reports a failure");

endmodule

bind walking_one_memory_test wot_chk u_wot_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kind_i         (kind_o),
  .address_i      (address_o),
  .write_data_i   (write_data_o),
  .fail_i         (fail_o),
  .out_of_range_i (out_of_range_o),
  .last_i         (last_o)
);
